// ===== design/lcdn_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdn_pkg
// Shared types, codes and constants for the 4-bit character LCD sequencer.
// ----------------------------------------------------------------------------
package lcdn_pkg;

  // request opcodes
  localparam logic [1:0] OP_COMMAND = 2'd0;
  localparam logic [1:0] OP_DATA    = 2'd1;
  localparam logic [1:0] OP_CURSOR  = 2'd2;
  localparam logic [1:0] OP_INIT    = 2'd3;

  // job kinds after classification
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_INIT = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_STROBE_SETTLE = 3'd0;
  localparam logic [2:0] CFG_COMMAND_WAIT  = 3'd1;
  localparam logic [2:0] CFG_DATA_WAIT     = 3'd2;
  localparam logic [2:0] CFG_POWER_UP_WAIT = 3'd3;
  localparam logic [2:0] CFG_INIT_LONG     = 3'd4;
  localparam logic [2:0] CFG_INIT_SHORT    = 3'd5;

  // reset values
  localparam logic [9:0]  RST_STROBE_SETTLE = 10'd100;
  localparam logic [13:0] RST_COMMAND_WAIT  = 14'd2000;
  localparam logic [13:0] RST_DATA_WAIT     = 14'd50;
  localparam logic [15:0] RST_POWER_UP_WAIT = 16'd50000;
  localparam logic [13:0] RST_INIT_LONG     = 14'd5000;
  localparam logic [13:0] RST_INIT_SHORT    = 14'd150;

  // cursor base addresses
  localparam logic [7:0] ROW0_BASE = 8'h80;
  localparam logic [7:0] ROW1_BASE = 8'hC0;

  // initialize sequence
  localparam logic [3:0] INIT_NIB_WAKE   = 4'h3;
  localparam logic [3:0] INIT_NIB_4BIT   = 4'h2;
  localparam logic [3:0] INIT_FIRST_BYTE = 4'd5;
  localparam logic [3:0] INIT_LAST_STEP  = 4'd12;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } job_t;

  typedef struct packed {
    logic [9:0]  strobe_settle;
    logic [13:0] command_wait;
    logic [13:0] data_wait;
    logic [15:0] power_up_wait;
    logic [13:0] init_long;
    logic [13:0] init_short;
  } cfg_t;

  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h28;
      2'd1:    b = 8'h0C;
      2'd2:    b = 8'h06;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

endpackage

// ===== design/char_lcd_nibble_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// 4-bit character LCD sequencer: requests in, enable strobes and waits out.
//
//   channel | direction | handshake          | payload
//   in_     | slave     | tvalid/tready      | tdata: byte_value, row, col; tuser: opcode
//   out_    | master    | tvalid/tready/last | tdata: nibble, wait_us; tuser: strobe, rs
//   cfg_    | write     | cfg_wr_en          | cfg_index, cfg_data
//
// A byte, data or cursor request gives 2 output items, initialize gives 13;
// items go out one per cycle unless the output stalls; a job is taken only when idle.
// A four-entry job queue lets requests be taken while items are still going out.
// Reset is synchronous and active low; registers return to their reset values.
// A stalled output holds the sequencer, which in turn fills the queue.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // byte_value[7:0], row[8], col[14:9], zero[15]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // nibble[3:0], wait_us[19:4], zero[23:20]
  output logic [1:0]  out_tuser,  // strobe_res[0], reg_select[1]
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lcdn_pkg::*;

  cfg_t cfg_r;
  job_t push_job;
  job_t head_job;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.strobe_settle <= RST_STROBE_SETTLE;
      cfg_r.command_wait  <= RST_COMMAND_WAIT;
      cfg_r.data_wait     <= RST_DATA_WAIT;
      cfg_r.power_up_wait <= RST_POWER_UP_WAIT;
      cfg_r.init_long     <= RST_INIT_LONG;
      cfg_r.init_short    <= RST_INIT_SHORT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_STROBE_SETTLE: cfg_r.strobe_settle <= cfg_data[9:0];
        CFG_COMMAND_WAIT:  cfg_r.command_wait  <= cfg_data[13:0];
        CFG_DATA_WAIT:     cfg_r.data_wait     <= cfg_data[13:0];
        CFG_POWER_UP_WAIT: cfg_r.power_up_wait <= cfg_data;
        CFG_INIT_LONG:     cfg_r.init_long     <= cfg_data[13:0];
        CFG_INIT_SHORT:    cfg_r.init_short    <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  lcdn_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  lcdn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .pop       (q_pop),
    .head_job  (head_job),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  lcdn_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .head_job    (head_job),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

// ===== design/lcdn_front.sv =====
// ----------------------------------------------------------------------------
// lcdn_front
// Accepts requests and classifies them into byte or initialize jobs.
// ----------------------------------------------------------------------------
module lcdn_front (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // byte_value[7:0], row[8], col[14:9]
  input  logic [1:0]        in_tuser,   // opcode[1:0]
  input  logic              q_full,
  output logic              q_push,
  output lcdn_pkg::job_t    q_job
);
  import lcdn_pkg::*;

  logic [7:0] byte_value;
  logic       row;
  logic [5:0] col;

  assign byte_value = in_tdata[7:0];
  assign row        = in_tdata[8];
  assign col        = in_tdata[14:9];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    case (in_tuser)
      OP_COMMAND: begin
        q_job.kind  = KIND_CMD;
        q_job.value = byte_value;
      end
      OP_DATA: begin
        q_job.kind  = KIND_DATA;
        q_job.value = byte_value;
      end
      OP_CURSOR: begin
        q_job.kind  = KIND_CMD;
        q_job.value = (row ? ROW1_BASE : ROW0_BASE) + {2'b00, col};
      end
      default: begin
        q_job.kind  = KIND_INIT;
        q_job.value = 8'h00;
      end
    endcase
  end

endmodule

// ===== design/lcdn_queue.sv =====
// ----------------------------------------------------------------------------
// lcdn_queue
// Short job queue between the classifier and the nibble sequencer.
// ----------------------------------------------------------------------------
module lcdn_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lcdn_pkg::job_t push_job,
  input  logic           pop,
  output lcdn_pkg::job_t head_job,
  output logic           not_empty,
  output logic           full
);
  import lcdn_pkg::*;

  job_t             mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     count_r, count_nxt;
  logic             do_pop;

  assign full      = (count_r == QAW'(0) + (QAW+1)'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign do_pop    = pop && not_empty;
  assign head_job  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/lcdn_back.sv =====
// ----------------------------------------------------------------------------
// lcdn_back
// Expands one job at a time into enable strobes and waits, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module lcdn_back (
  input  logic           clk,
  input  logic           rst_n,
  input  lcdn_pkg::cfg_t cfg,
  input  lcdn_pkg::job_t head_job,
  input  logic           q_not_empty,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [23:0]    out_tdata,  // nibble[3:0], wait_us[19:4], zero[23:20]
  output logic [1:0]     out_tuser,  // strobe_res[0], reg_select[1]
  output logic           out_tlast
);
  import lcdn_pkg::*;

  logic        busy_r;
  logic [3:0]  step_r;
  job_t        job_r;
  logic        out_valid_r;
  logic        strobe_r;
  logic        rs_r;
  logic [3:0]  nib_r;
  logic [15:0] wait_r;
  logic        last_r;

  logic        load;
  logic        advance;
  logic [3:0]  sub;
  logic        is_init;
  logic        lo;
  logic [7:0]  byte_sel;
  logic [14:0] extra;
  logic [15:0] term_a;
  logic [14:0] term_b;
  logic [16:0] wait_sum;
  logic        item_strobe;
  logic        item_rs;
  logic [3:0]  item_nib;
  logic [15:0] item_wait;
  logic        item_last;

  assign load    = !busy_r && q_not_empty;
  assign q_pop   = load;
  assign advance = busy_r && (!out_valid_r || out_tready);

  always_comb begin
    is_init  = (job_r.kind == KIND_INIT);
    sub      = step_r - INIT_FIRST_BYTE;
    byte_sel = is_init ? init_byte(sub[2:1]) : job_r.value;
    lo       = is_init ? sub[0] : step_r[0];
    if (is_init && step_r == INIT_LAST_STEP) begin
      extra = {cfg.command_wait, 1'b0};
    end else if (job_r.kind == KIND_DATA) begin
      extra = {1'b0, cfg.data_wait};
    end else begin
      extra = {1'b0, cfg.command_wait};
    end
    item_strobe = 1'b1;
    item_rs     = (job_r.kind == KIND_DATA);
    term_a      = {6'd0, cfg.strobe_settle};
    term_b      = '0;
    item_last   = 1'b0;
    item_nib    = lo ? byte_sel[3:0] : byte_sel[7:4];
    if (is_init && step_r < INIT_FIRST_BYTE) begin
      item_rs = 1'b0;
      case (step_r)
        4'd0: begin
          item_strobe = 1'b0;
          item_nib    = 4'h0;
          term_a      = cfg.power_up_wait;
        end
        4'd1: begin
          item_nib = INIT_NIB_WAKE;
          term_b   = {1'b0, cfg.init_long};
        end
        4'd2: begin
          item_nib = INIT_NIB_WAKE;
          term_b   = {1'b0, cfg.init_short};
        end
        4'd3: begin
          item_nib = INIT_NIB_WAKE;
        end
        default: begin
          item_nib = INIT_NIB_4BIT;
        end
      endcase
    end else begin
      if (lo) begin
        term_b = extra;
      end
      item_last = lo && (!is_init || step_r == INIT_LAST_STEP);
    end
    wait_sum  = {1'b0, term_a} + {2'b00, term_b};
    item_wait = wait_sum[16] ? 16'hFFFF : wait_sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= head_job;
    end
    if (advance) begin
      strobe_r <= item_strobe;
      rs_r     <= item_rs;
      nib_r    <= item_nib;
      wait_r   <= item_wait;
      last_r   <= item_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (advance) begin
        if (item_last) begin
          busy_r <= 1'b0;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, wait_r, nib_r};
  assign out_tuser  = {rs_r, strobe_r};
  assign out_tlast  = last_r;

  a_byte_two_steps: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && job_r.kind != KIND_INIT |-> step_r <= 4'd1)
    else $error("byte job ran past its second nibble");

  a_init_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r <= INIT_LAST_STEP)
    else $error("step counter ran past the initialize sequence");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item_last |=> !busy_r)
    else $error("sequencer stayed busy after the final item");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !busy_r && q_not_empty)
    else $error("job taken while another was still running");

endmodule
